@@ rtl/projected_box_bounds_core_defines.svh @@
// ----------------------------------------------------------------------------
// projected_box_bounds_core_defines.svh
// Assertion macros used by the port checker of the block.
// ----------------------------------------------------------------------------
`ifndef PROJECTED_BOX_BOUNDS_CORE_DEFINES_SVH
`define PROJECTED_BOX_BOUNDS_CORE_DEFINES_SVH

// same-cycle implication
`define PBB_ASSERT_NOW(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("same-cycle check failed");

// next-cycle implication
`define PBB_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("next-cycle check failed");

`endif

@@ rtl/pbb_pkg.sv @@
// ----------------------------------------------------------------------------
// pbb_pkg
// Types and constants shared by the projected box bounds modules.
// ----------------------------------------------------------------------------
package pbb_pkg;

  localparam int unsigned CORNERS = 8;
  localparam int unsigned CNT_W   = 3;

  typedef enum logic [2:0] {
    CFG_ROW_X_LO    = 3'd0,
    CFG_ROW_X_HI    = 3'd1,
    CFG_ROW_Y_LO    = 3'd2,
    CFG_ROW_Y_HI    = 3'd3,
    CFG_ROW_W_LO    = 3'd4,
    CFG_ROW_W_HI    = 3'd5,
    CFG_SCREEN_W    = 3'd6,
    CFG_SCREEN_H    = 3'd7
  } cfg_idx_e;

  typedef struct packed {
    logic signed [31:0] origin_x;
    logic signed [31:0] origin_y;
    logic signed [31:0] origin_z;
    logic signed [31:0] min_off_x;
    logic signed [31:0] min_off_y;
    logic signed [31:0] min_off_z;
    logic signed [31:0] max_off_x;
    logic signed [31:0] max_off_y;
    logic signed [31:0] max_off_z;
  } pbb_in_t;

  typedef struct packed {
    logic               valid_res;
    logic signed [15:0] box_left;
    logic signed [15:0] box_top;
    logic [14:0]        box_width;
    logic [14:0]        box_height;
  } pbb_out_t;

  typedef struct packed {
    logic signed [31:0] m3;
    logic signed [31:0] m2;
    logic signed [31:0] m1;
    logic signed [31:0] m0;
  } pbb_row_t;

  typedef struct packed {
    pbb_row_t    row_x;
    pbb_row_t    row_y;
    pbb_row_t    row_w;
    logic [13:0] scr_w;
    logic [13:0] scr_h;
  } pbb_cfg_t;

  typedef struct packed {
    logic signed [31:0] x;
    logic signed [31:0] y;
    logic signed [31:0] z;
  } pbb_point_t;

  // travels with each corner down the pipe
  typedef struct packed {
    logic valid;
    logic first;
    logic last;
  } pbb_tag_t;

endpackage

@@ rtl/projected_box_bounds_core.sv @@
// ----------------------------------------------------------------------------
// projected_box_bounds_core
// Screen rectangle enclosing the perspective projection of a 3-D box.
// ----------------------------------------------------------------------------
// A box word (origin plus min and max corner offsets) enters on in_valid_i /
// in_ready_o. Its eight corners go one per cycle, unless the output stalls,
// through the matrix stage, a bit-per-stage divider of 32 + FRAC_BITS stages
// and the screen mapping, and one result word leaves on out_valid_o /
// out_ready_i. A new box word is taken only while idle or while the last
// corner of the previous one issues, set by the single corner datapath.
// Matrix rows and screen size are written on the cfg channel, which is always
// ready; write them only while no box is in flight.
// Reset clears the pipe and loads a zero matrix and a 1920x1080 screen.
// When the receiver holds out_ready_i low with a result waiting, the whole
// pipe freezes and in_ready_o drops; nothing is lost or repeated.
// ----------------------------------------------------------------------------
module projected_box_bounds_core #(
  parameter int unsigned FRAC_BITS = 16
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  pbb_pkg::pbb_in_t  in_data_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output pbb_pkg::pbb_out_t out_data_o,
  input  logic              cfg_valid_i,
  output logic              cfg_ready_o,
  input  logic [2:0]        cfg_index_i,
  input  logic [63:0]       cfg_data_i
);
  import pbb_pkg::*;

  pbb_cfg_t           cfg_q;
  logic               en;
  pbb_point_t         point;
  pbb_tag_t           tag_seq, tag_proj, tag_div;
  logic signed [31:0] cx, cy, cw, nx, ny;
  logic               bad;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.row_x <= '0;
      cfg_q.row_y <= '0;
      cfg_q.row_w <= '0;
      cfg_q.scr_w <= 14'd1920;
      cfg_q.scr_h <= 14'd1080;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        CFG_ROW_X_LO: {cfg_q.row_x.m1, cfg_q.row_x.m0} <= cfg_data_i;
        CFG_ROW_X_HI: {cfg_q.row_x.m3, cfg_q.row_x.m2} <= cfg_data_i;
        CFG_ROW_Y_LO: {cfg_q.row_y.m1, cfg_q.row_y.m0} <= cfg_data_i;
        CFG_ROW_Y_HI: {cfg_q.row_y.m3, cfg_q.row_y.m2} <= cfg_data_i;
        CFG_ROW_W_LO: {cfg_q.row_w.m1, cfg_q.row_w.m0} <= cfg_data_i;
        CFG_ROW_W_HI: {cfg_q.row_w.m3, cfg_q.row_w.m2} <= cfg_data_i;
        CFG_SCREEN_W: cfg_q.scr_w <= cfg_data_i[13:0];
        CFG_SCREEN_H: cfg_q.scr_h <= cfg_data_i[13:0];
        default: ;
      endcase
    end
  end

  pbb_corner_seq u_seq (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .en_i       (en),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_data_i  (in_data_i),
    .point_o    (point),
    .tag_o      (tag_seq)
  );

  pbb_proj #(.FRAC_BITS(FRAC_BITS)) u_proj (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .cfg_i   (cfg_q),
    .point_i (point),
    .tag_i   (tag_seq),
    .cx_o    (cx),
    .cy_o    (cy),
    .cw_o    (cw),
    .tag_o   (tag_proj)
  );

  pbb_div #(.FRAC_BITS(FRAC_BITS)) u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (en),
    .cx_i   (cx),
    .cy_i   (cy),
    .cw_i   (cw),
    .tag_i  (tag_proj),
    .nx_o   (nx),
    .ny_o   (ny),
    .bad_o  (bad),
    .tag_o  (tag_div)
  );

  pbb_acc #(.FRAC_BITS(FRAC_BITS)) u_acc (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .scr_w_i     (cfg_q.scr_w),
    .scr_h_i     (cfg_q.scr_h),
    .nx_i        (nx),
    .ny_i        (ny),
    .bad_i       (bad),
    .tag_i       (tag_div),
    .en_o        (en),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

endmodule

@@ rtl/pbb_corner_seq.sv @@
// ----------------------------------------------------------------------------
// pbb_corner_seq
// Takes one box word, forms both corners and issues the eight corners.
// ----------------------------------------------------------------------------
module pbb_corner_seq (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               en_i,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  pbb_pkg::pbb_in_t   in_data_i,
  output pbb_pkg::pbb_point_t point_o,
  output pbb_pkg::pbb_tag_t   tag_o
);
  import pbb_pkg::*;

  function automatic logic signed [31:0] sat_add(logic signed [31:0] a,
                                                 logic signed [31:0] b);
    logic signed [32:0] s;
    s = 33'(a) + 33'(b);
    if (s[32] != s[31]) begin
      return s[32] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
    end
    return s[31:0];
  endfunction

  pbb_point_t lo_q, hi_q, point_q;
  pbb_tag_t   tag_q;
  logic [CNT_W-1:0] cnt_q;
  logic       busy_q;
  logic       accept, issue, last_corner;

  assign last_corner = (cnt_q == CNT_W'(CORNERS - 1));
  assign in_ready_o  = en_i && (!busy_q || last_corner);
  assign accept      = in_valid_i && in_ready_o;
  assign issue       = en_i && busy_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
      tag_q  <= '0;
    end else if (en_i) begin
      tag_q.valid <= busy_q;
      tag_q.first <= (cnt_q == '0);
      tag_q.last  <= last_corner;
      if (accept) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (issue) begin
        cnt_q  <= cnt_q + CNT_W'(1);
        busy_q <= !last_corner;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      lo_q.x <= sat_add(in_data_i.origin_x, in_data_i.min_off_x);
      lo_q.y <= sat_add(in_data_i.origin_y, in_data_i.min_off_y);
      lo_q.z <= sat_add(in_data_i.origin_z, in_data_i.min_off_z);
      hi_q.x <= sat_add(in_data_i.origin_x, in_data_i.max_off_x);
      hi_q.y <= sat_add(in_data_i.origin_y, in_data_i.max_off_y);
      hi_q.z <= sat_add(in_data_i.origin_z, in_data_i.max_off_z);
    end
    if (issue) begin
      point_q.x <= cnt_q[0] ? hi_q.x : lo_q.x;
      point_q.y <= cnt_q[1] ? hi_q.y : lo_q.y;
      point_q.z <= cnt_q[2] ? hi_q.z : lo_q.z;
    end
  end

  assign point_o = point_q;
  assign tag_o   = tag_q;

endmodule

@@ rtl/pbb_proj.sv @@
// ----------------------------------------------------------------------------
// pbb_proj
// Two-stage matrix transform of one corner into clip x, y and w.
// ----------------------------------------------------------------------------
module pbb_proj #(
  parameter int unsigned FRAC_BITS = 16
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                en_i,
  input  pbb_pkg::pbb_cfg_t   cfg_i,
  input  pbb_pkg::pbb_point_t point_i,
  input  pbb_pkg::pbb_tag_t   tag_i,
  output logic signed [31:0]  cx_o,
  output logic signed [31:0]  cy_o,
  output logic signed [31:0]  cw_o,
  output pbb_pkg::pbb_tag_t   tag_o
);
  import pbb_pkg::*;

  pbb_row_t           rows [3];
  logic signed [31:0] mat  [3][3];
  logic signed [31:0] ofs  [3];
  logic signed [31:0] crd  [3];
  logic signed [63:0] prod_q [3][3];
  logic signed [65:0] sum  [3];
  logic signed [31:0] clip_d [3];
  logic signed [31:0] clip_q [3];
  pbb_tag_t           tag_a_q, tag_b_q;

  assign rows[0] = cfg_i.row_x;
  assign rows[1] = cfg_i.row_y;
  assign rows[2] = cfg_i.row_w;
  assign crd[0]  = point_i.x;
  assign crd[1]  = point_i.y;
  assign crd[2]  = point_i.z;

  always_comb begin
    for (int r = 0; r < 3; r++) begin
      mat[r][0] = rows[r].m0;
      mat[r][1] = rows[r].m1;
      mat[r][2] = rows[r].m2;
      ofs[r]    = rows[r].m3;
    end
  end

  // floor shift of each product, sum with the offset column, saturate
  always_comb begin
    for (int r = 0; r < 3; r++) begin
      sum[r] = 66'(prod_q[r][0] >>> FRAC_BITS) + 66'(prod_q[r][1] >>> FRAC_BITS)
             + 66'(prod_q[r][2] >>> FRAC_BITS) + 66'(ofs[r]);
      if (sum[r] > 66'sh7FFF_FFFF) begin
        clip_d[r] = 32'sh7FFF_FFFF;
      end else if (sum[r] < -(66'sh8000_0000)) begin
        clip_d[r] = 32'sh8000_0000;
      end else begin
        clip_d[r] = sum[r][31:0];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tag_a_q <= '0;
      tag_b_q <= '0;
    end else if (en_i) begin
      tag_a_q <= tag_i;
      tag_b_q <= tag_a_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int r = 0; r < 3; r++) begin
        for (int c = 0; c < 3; c++) begin
          prod_q[r][c] <= 64'(mat[r][c]) * 64'(crd[c]);
        end
        clip_q[r] <= clip_d[r];
      end
    end
  end

  assign cx_o  = clip_q[0];
  assign cy_o  = clip_q[1];
  assign cw_o  = clip_q[2];
  assign tag_o = tag_b_q;

endmodule

@@ rtl/pbb_div.sv @@
// ----------------------------------------------------------------------------
// pbb_div
// Pipelined restoring divider: clip x and y over clip w, one quotient bit
// per stage, with the behind-camera test and signed saturation.
// ----------------------------------------------------------------------------
module pbb_div #(
  parameter int unsigned FRAC_BITS = 16
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               en_i,
  input  logic signed [31:0] cx_i,
  input  logic signed [31:0] cy_i,
  input  logic signed [31:0] cw_i,
  input  pbb_pkg::pbb_tag_t  tag_i,
  output logic signed [31:0] nx_o,
  output logic signed [31:0] ny_o,
  output logic               bad_o,
  output pbb_pkg::pbb_tag_t  tag_o
);
  import pbb_pkg::*;

  localparam int unsigned NW = 32 + FRAC_BITS;
  // smallest w that still counts as in front of the camera
  localparam logic signed [31:0] W_MIN = 32'((2 ** FRAC_BITS + 999) / 1000);
  localparam logic [NW-1:0] POS_MAX = NW'(64'h7FFF_FFFF);
  localparam logic [NW-1:0] NEG_MAG = NW'(64'h8000_0000);

  typedef struct packed {
    pbb_tag_t        tag;
    logic            bad;
    logic            negx;
    logic            negy;
    logic [30:0]     d;
    logic [30:0]     rx;
    logic [30:0]     ry;
    logic [NW-1:0]   qx;
    logic [NW-1:0]   qy;
  } dstage_t;

  function automatic logic [NW+30:0] div_step(logic [30:0] r, logic [NW-1:0] q,
                                              logic [30:0] d);
    logic [31:0] t;
    logic [31:0] diff;
    t    = {r, q[NW-1]};
    diff = t - {1'b0, d};
    if (t >= {1'b0, d}) begin
      return {diff[30:0], q[NW-2:0], 1'b1};
    end
    return {t[30:0], q[NW-2:0], 1'b0};
  endfunction

  function automatic logic signed [31:0] sat_q(logic [NW-1:0] q, logic neg);
    if (neg) begin
      return (q > NEG_MAG) ? 32'sh8000_0000 : 32'(~q[31:0] + 32'd1);
    end
    return (q > POS_MAX) ? 32'sh7FFF_FFFF : 32'(q[31:0]);
  endfunction

  dstage_t            st_q [NW+1];
  dstage_t            st0_d;
  logic [31:0]        magx, magy;
  logic signed [31:0] nx_q, ny_q;
  logic               bad_q;
  pbb_tag_t           tag_q;

  always_comb begin
    magx         = cx_i[31] ? 32'(~cx_i + 32'sd1) : 32'(cx_i);
    magy         = cy_i[31] ? 32'(~cy_i + 32'sd1) : 32'(cy_i);
    st0_d.tag    = tag_i;
    st0_d.bad    = (cw_i < W_MIN);
    st0_d.negx   = cx_i[31];
    st0_d.negy   = cy_i[31];
    // a w that fails the test is never used, keep the divisor nonzero
    st0_d.d      = st0_d.bad ? 31'd1 : cw_i[30:0];
    st0_d.rx     = '0;
    st0_d.ry     = '0;
    st0_d.qx     = {magx, {FRAC_BITS{1'b0}}};
    st0_d.qy     = {magy, {FRAC_BITS{1'b0}}};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q[0] <= '0;
    end else if (en_i) begin
      st_q[0] <= st0_d;
    end
  end

  for (genvar j = 1; j <= NW; j++) begin : g_step
    dstage_t nxt;

    always_comb begin
      nxt               = st_q[j-1];
      {nxt.rx, nxt.qx}  = div_step(st_q[j-1].rx, st_q[j-1].qx, st_q[j-1].d);
      {nxt.ry, nxt.qy}  = div_step(st_q[j-1].ry, st_q[j-1].qy, st_q[j-1].d);
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        st_q[j] <= '0;
      end else if (en_i) begin
        st_q[j] <= nxt;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tag_q <= '0;
    end else if (en_i) begin
      tag_q <= st_q[NW].tag;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      nx_q  <= sat_q(st_q[NW].qx, st_q[NW].negx);
      ny_q  <= sat_q(st_q[NW].qy, st_q[NW].negy);
      bad_q <= st_q[NW].bad;
    end
  end

  assign nx_o  = nx_q;
  assign ny_o  = ny_q;
  assign bad_o = bad_q;
  assign tag_o = tag_q;

endmodule

@@ rtl/pbb_acc.sv @@
// ----------------------------------------------------------------------------
// pbb_acc
// Screen mapping, running min/max over the corners and the result register.
// ----------------------------------------------------------------------------
module pbb_acc #(
  parameter int unsigned FRAC_BITS = 16
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic [13:0]        scr_w_i,
  input  logic [13:0]        scr_h_i,
  input  logic signed [31:0] nx_i,
  input  logic signed [31:0] ny_i,
  input  logic               bad_i,
  input  pbb_pkg::pbb_tag_t  tag_i,
  output logic               en_o,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output pbb_pkg::pbb_out_t  out_data_o
);
  import pbb_pkg::*;

  localparam int unsigned PW = 50;
  localparam logic signed [33:0]   ONE    = 34'(2 ** FRAC_BITS);
  localparam logic signed [PW-1:0] UNIT_M1 = PW'(2 ** (FRAC_BITS + 1) - 1);

  function automatic logic signed [PW-1:0] trunc_div(logic signed [PW-1:0] v);
    if (v < 0) begin
      return (v + UNIT_M1) >>> (FRAC_BITS + 1);
    end
    return v >>> (FRAC_BITS + 1);
  endfunction

  function automatic logic signed [15:0] sat16(logic signed [PW-1:0] v);
    if (v > PW'(32767)) begin
      return 16'sh7FFF;
    end else if (v < -(PW'(32768))) begin
      return 16'sh8000;
    end
    return v[15:0];
  endfunction

  function automatic logic [14:0] sat15(logic signed [PW-1:0] v);
    return (v > PW'(32767)) ? 15'h7FFF : v[14:0];
  endfunction

  logic signed [33:0]   ax, ay;
  logic signed [PW-1:0] sx_q, sy_q;
  logic                 bad_s_q;
  pbb_tag_t             tag_s_q;

  logic signed [PW-1:0] minx_q, maxx_q, miny_q, maxy_q;
  logic signed [PW-1:0] minx_d, maxx_d, miny_d, maxy_d;
  logic                 ok_q, ok_d;

  logic signed [PW-1:0] fminx_q, fmaxx_q, fminy_q, fmaxy_q;
  logic                 fok_q, fin_v_q;

  logic                 out_v_q;
  pbb_out_t             out_q, out_d;

  assign en_o = !out_v_q || out_ready_i;
  assign ax   = 34'(nx_i) + ONE;
  assign ay   = ONE - 34'(ny_i);

  // running bounds, the first corner of a box restarts them
  always_comb begin
    if (tag_s_q.first) begin
      minx_d = sx_q;
      maxx_d = sx_q;
      miny_d = sy_q;
      maxy_d = sy_q;
      ok_d   = !bad_s_q;
    end else begin
      minx_d = (sx_q < minx_q) ? sx_q : minx_q;
      maxx_d = (sx_q > maxx_q) ? sx_q : maxx_q;
      miny_d = (sy_q < miny_q) ? sy_q : miny_q;
      maxy_d = (sy_q > maxy_q) ? sy_q : maxy_q;
      ok_d   = ok_q && !bad_s_q;
    end
  end

  always_comb begin
    out_d = '0;
    if (fok_q) begin
      out_d.valid_res  = 1'b1;
      out_d.box_left   = sat16(trunc_div(fminx_q));
      out_d.box_top    = sat16(trunc_div(fminy_q));
      out_d.box_width  = sat15(trunc_div(fmaxx_q - fminx_q));
      out_d.box_height = sat15(trunc_div(fmaxy_q - fminy_q));
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tag_s_q <= '0;
      fin_v_q <= 1'b0;
      out_v_q <= 1'b0;
    end else if (en_o) begin
      tag_s_q <= tag_i;
      fin_v_q <= tag_s_q.valid && tag_s_q.last;
      out_v_q <= fin_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_o) begin
      sx_q    <= PW'($signed({1'b0, scr_w_i})) * PW'(ax);
      sy_q    <= PW'($signed({1'b0, scr_h_i})) * PW'(ay);
      bad_s_q <= bad_i;
      if (tag_s_q.valid) begin
        minx_q <= minx_d;
        maxx_q <= maxx_d;
        miny_q <= miny_d;
        maxy_q <= maxy_d;
        ok_q   <= ok_d;
      end
      if (tag_s_q.valid && tag_s_q.last) begin
        fminx_q <= minx_d;
        fmaxx_q <= maxx_d;
        fminy_q <= miny_d;
        fmaxy_q <= maxy_d;
        fok_q   <= ok_d;
      end
      if (fin_v_q) begin
        out_q <= out_d;
      end
    end
  end

  assign out_valid_o = out_v_q;
  assign out_data_o  = out_q;

endmodule

@@ rtl/pbb_port_checker.sv @@
// ----------------------------------------------------------------------------
// pbb_port_checker
// Port-level checks on projected_box_bounds_core, attached by bind.
// ----------------------------------------------------------------------------
`include "projected_box_bounds_core_defines.svh"

module pbb_port_checker (
  input logic              clk_i,
  input logic              rst_ni,
  input logic              in_valid_i,
  input logic              in_ready_o,
  input logic              out_valid_o,
  input logic              out_ready_i,
  input pbb_pkg::pbb_out_t out_data_o
);

  // a stalled result word holds
  `PBB_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, out_valid_o && !out_ready_i, out_valid_o && $stable(out_data_o))

  // a box behind the camera reports an empty rectangle
  `PBB_ASSERT_NOW(a_invalid_zero, clk_i, rst_ni, out_valid_o && !out_data_o.valid_res, out_data_o == '0)

  // eight corners per box: no second word right after one is taken
  `PBB_ASSERT_NEXT(a_ready_gap, clk_i, rst_ni, in_valid_i && in_ready_o, !in_ready_o)

  // a blocked output freezes the input side
  `PBB_ASSERT_NOW(a_stall_blocks_in, clk_i, rst_ni, out_valid_o && !out_ready_i, !in_ready_o)

endmodule

bind projected_box_bounds_core pbb_port_checker u_pbb_port_checker (.*);

@@ sim/pbb_bounds_checker.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// pbb_bounds_checker
// Watches the box, result and register channels of the projected box bounds
// core, predicts the screen rectangle of every accepted box word and compares
// each result word field by field with the oldest prediction.
// ----------------------------------------------------------------------------
module pbb_bounds_checker
  import pbb_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  input  logic        in_ready_i,
  input  pbb_in_t     in_data_i,
  input  logic        out_valid_i,
  input  logic        out_ready_i,
  input  pbb_out_t    out_data_i,
  input  logic        cfg_valid_i,
  input  logic        cfg_ready_i,
  input  logic [2:0]  cfg_index_i,
  input  logic [63:0] cfg_data_i,
  output int          fail_count_o,
  output int          pending_o
);

  localparam int FRAC = 16;

  // matrix rows x, y, w; columns 0..3
  longint      view_m[3][4];
  logic [13:0] scr_w, scr_h;
  pbb_out_t    bounds_q[$];

  function automatic longint sat32(longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  function automatic longint clamp(longint v, longint lo, longint hi);
    return v < lo ? lo : (v > hi ? hi : v);
  endfunction

  function automatic longint sx32(logic [31:0] v);
    return longint'(int'(v));
  endfunction

  function automatic longint clip_dot(int r, longint px, longint py, longint pz);
    longint acc;
    acc = ((view_m[r][0] * px) >>> FRAC) + ((view_m[r][1] * py) >>> FRAC)
        + ((view_m[r][2] * pz) >>> FRAC) + view_m[r][3];
    return sat32(acc);
  endfunction

  function automatic pbb_out_t project_bounds(pbb_in_t d);
    longint   lo_c[3], hi_c[3], org[3], p[3], c[3];
    longint   one, unit, nx, ny, sx2, sy2, minx, maxx, miny, maxy;
    bit       front;
    pbb_out_t r;
    one = 64'sd1 <<< FRAC;
    unit = one * 2;
    front = 1'b1;
    minx = 0; maxx = 0; miny = 0; maxy = 0;
    org[0] = sx32(d.origin_x); org[1] = sx32(d.origin_y); org[2] = sx32(d.origin_z);
    lo_c[0] = sat32(org[0] + sx32(d.min_off_x));
    lo_c[1] = sat32(org[1] + sx32(d.min_off_y));
    lo_c[2] = sat32(org[2] + sx32(d.min_off_z));
    hi_c[0] = sat32(org[0] + sx32(d.max_off_x));
    hi_c[1] = sat32(org[1] + sx32(d.max_off_y));
    hi_c[2] = sat32(org[2] + sx32(d.max_off_z));
    for (int k = 0; k < 8; k++) begin
      for (int a = 0; a < 3; a++) p[a] = k[a] ? hi_c[a] : lo_c[a];
      for (int m = 0; m < 3; m++) c[m] = clip_dot(m, p[0], p[1], p[2]);
      // behind the camera: w below 0.001
      if (c[2] * 1000 < one) begin
        front = 1'b0;
        continue;
      end
      nx = sat32((c[0] * one) / c[2]);
      ny = sat32((c[1] * one) / c[2]);
      sx2 = longint'(scr_w) * (one + nx);
      sy2 = longint'(scr_h) * (one - ny);
      if (k == 0 || sx2 < minx) minx = sx2;
      if (k == 0 || sx2 > maxx) maxx = sx2;
      if (k == 0 || sy2 < miny) miny = sy2;
      if (k == 0 || sy2 > maxy) maxy = sy2;
    end
    r = '0;
    if (front) begin
      r.valid_res  = 1'b1;
      r.box_left   = 16'(clamp(minx / unit, -32768, 32767));
      r.box_top    = 16'(clamp(miny / unit, -32768, 32767));
      r.box_width  = 15'(clamp((maxx - minx) / unit, 0, 32767));
      r.box_height = 15'(clamp((maxy - miny) / unit, 0, 32767));
    end
    return r;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    pbb_out_t want;
    if (!rst_ni) begin
      for (int m = 0; m < 3; m++) for (int n = 0; n < 4; n++) view_m[m][n] = 0;
      scr_w = 14'd1920;
      scr_h = 14'd1080;
      bounds_q.delete();
      fail_count_o = 0;
    end else begin
      if (cfg_valid_i && cfg_ready_i) begin
        case (cfg_idx_e'(cfg_index_i))
          CFG_ROW_X_LO: begin view_m[0][0] = sx32(cfg_data_i[31:0]);
                              view_m[0][1] = sx32(cfg_data_i[63:32]); end
          CFG_ROW_X_HI: begin view_m[0][2] = sx32(cfg_data_i[31:0]);
                              view_m[0][3] = sx32(cfg_data_i[63:32]); end
          CFG_ROW_Y_LO: begin view_m[1][0] = sx32(cfg_data_i[31:0]);
                              view_m[1][1] = sx32(cfg_data_i[63:32]); end
          CFG_ROW_Y_HI: begin view_m[1][2] = sx32(cfg_data_i[31:0]);
                              view_m[1][3] = sx32(cfg_data_i[63:32]); end
          CFG_ROW_W_LO: begin view_m[2][0] = sx32(cfg_data_i[31:0]);
                              view_m[2][1] = sx32(cfg_data_i[63:32]); end
          CFG_ROW_W_HI: begin view_m[2][2] = sx32(cfg_data_i[31:0]);
                              view_m[2][3] = sx32(cfg_data_i[63:32]); end
          CFG_SCREEN_W: scr_w = cfg_data_i[13:0];
          CFG_SCREEN_H: scr_h = cfg_data_i[13:0];
          default: ;
        endcase
      end
      if (out_valid_i && out_ready_i) begin
        if (bounds_q.size() == 0) begin
          fail_count_o++;
          if (fail_count_o <= 10)
            $display("%0t: result word with nothing expected: %h", $time, out_data_i);
        end else begin
          want = bounds_q.pop_front();
          if (out_data_i.valid_res !== want.valid_res || out_data_i.box_left !== want.box_left ||
              out_data_i.box_top !== want.box_top || out_data_i.box_width !== want.box_width ||
              out_data_i.box_height !== want.box_height) begin
            fail_count_o++;
            if (fail_count_o <= 10)
              $display({"%0t: mismatch exp v=%0d l=%0d t=%0d w=%0d h=%0d",
                        " got v=%0d l=%0d t=%0d w=%0d h=%0d"},
                       $time, want.valid_res, want.box_left, want.box_top, want.box_width,
                       want.box_height, out_data_i.valid_res, out_data_i.box_left,
                       out_data_i.box_top, out_data_i.box_width, out_data_i.box_height);
          end
        end
      end
      if (in_valid_i && in_ready_i) bounds_q = {bounds_q, project_bounds(in_data_i)};
    end
    pending_o = bounds_q.size();
  end

endmodule

@@ sim/tb_projected_box_bounds_core.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_projected_box_bounds_core
// Drives boxes and view settings into the projected box bounds core: a short
// directed set of corner cases, then phases of random boxes under several
// matrices and screen sizes, with random idling on both sides.
// ----------------------------------------------------------------------------
module tb_projected_box_bounds_core;
  import pbb_pkg::*;

  localparam int STALL_LIMIT = 4000;
  localparam int ONE = 65536;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  pbb_in_t     in_data = '0;
  logic        out_valid;
  logic        out_ready = 1'b1;
  pbb_out_t    out_data;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [2:0]  cfg_index = '0;
  logic [63:0] cfg_data = '0;
  int          fail_count;
  int          pending;
  int          stall_cnt = 0;
  bit          tx_idle = 1'b1;
  bit          rx_idle = 1'b1;
  bit          long_hold_req = 1'b0;

  projected_box_bounds_core dut (
    .clk_i(clk), .rst_ni(rst_n),
    .in_valid_i(in_valid), .in_ready_o(in_ready), .in_data_i(in_data),
    .out_valid_o(out_valid), .out_ready_i(out_ready), .out_data_o(out_data),
    .cfg_valid_i(cfg_valid), .cfg_ready_o(cfg_ready),
    .cfg_index_i(cfg_index), .cfg_data_i(cfg_data)
  );

  pbb_bounds_checker chk (
    .clk_i(clk), .rst_ni(rst_n),
    .in_valid_i(in_valid), .in_ready_i(in_ready), .in_data_i(in_data),
    .out_valid_i(out_valid), .out_ready_i(out_ready), .out_data_i(out_data),
    .cfg_valid_i(cfg_valid), .cfg_ready_i(cfg_ready),
    .cfg_index_i(cfg_index), .cfg_data_i(cfg_data),
    .fail_count_o(fail_count), .pending_o(pending)
  );

  initial begin
    forever #1 clk = ~clk;
  end

  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
      stall_cnt <= 0;
    else
      stall_cnt <= stall_cnt + 1;
    if (stall_cnt >= STALL_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  // receiver: random back-pressure, one long hold-off on request
  initial begin
    forever begin
      if (long_hold_req) begin
        out_ready <= 1'b0;
        repeat (400) @(posedge clk);
        long_hold_req = 1'b0;
      end else if (rx_idle && $urandom_range(0, 4) == 0) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(1, 13)) @(posedge clk);
      end else begin
        out_ready <= 1'b1;
        repeat ($urandom_range(1, 24)) @(posedge clk);
      end
    end
  end

  task automatic send_box(pbb_in_t d);
    bit hs;
    if (tx_idle && $urandom_range(0, 4) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 13)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= d;
    do begin
      @(negedge clk);
      hs = in_ready;
      @(posedge clk);
    end while (!hs);
  endtask

  task automatic cfg_write(cfg_idx_e idx, logic [63:0] v);
    bit hs;
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= v;
    do begin
      @(negedge clk);
      hs = cfg_ready;
      @(posedge clk);
    end while (!hs);
  endtask

  // lowers valid, waits out every pending result and the pipe latency
  task automatic drain();
    in_valid <= 1'b0;
    while (pending != 0) @(posedge clk);
    repeat (80) @(posedge clk);
  endtask

  function automatic logic [31:0] small_q(int span);
    return 32'($urandom_range(0, 2 * span)) - 32'(span);
  endfunction

  // wild: every matrix bit random; else a perspective view with jitter
  task automatic set_view(bit wild, int focal, int sw, int sh);
    if (wild) begin
      cfg_write(CFG_ROW_X_LO, {$urandom, $urandom});
      cfg_write(CFG_ROW_X_HI, {$urandom, $urandom});
      cfg_write(CFG_ROW_Y_LO, {$urandom, $urandom});
      cfg_write(CFG_ROW_Y_HI, {$urandom, $urandom});
      cfg_write(CFG_ROW_W_LO, {$urandom, $urandom});
      cfg_write(CFG_ROW_W_HI, {$urandom, $urandom});
    end else begin
      cfg_write(CFG_ROW_X_LO, {small_q(ONE / 16), 32'(focal)});
      cfg_write(CFG_ROW_X_HI, {small_q(ONE), small_q(ONE / 8)});
      cfg_write(CFG_ROW_Y_LO, {32'(focal), small_q(ONE / 16)});
      cfg_write(CFG_ROW_Y_HI, {small_q(ONE), small_q(ONE / 8)});
      cfg_write(CFG_ROW_W_LO, {small_q(ONE / 256), small_q(ONE / 256)});
      cfg_write(CFG_ROW_W_HI, {small_q(ONE / 4), 32'(ONE)});
    end
    cfg_write(CFG_SCREEN_W, 64'(sw));
    cfg_write(CFG_SCREEN_H, 64'(sh));
    cfg_valid <= 1'b0;
  endtask

  function automatic pbb_in_t cube(int ox, int oy, int oz, int half);
    pbb_in_t d;
    d.origin_x = ox; d.origin_y = oy; d.origin_z = oz;
    d.min_off_x = -half; d.min_off_y = -half; d.min_off_z = -half;
    d.max_off_x = half; d.max_off_y = half; d.max_off_z = half;
    return d;
  endfunction

  // a box in front of the camera, mostly inside the view
  function automatic pbb_in_t scene_box();
    pbb_in_t d;
    int zq;
    zq = $urandom_range(2, 300) * ONE + $urandom_range(0, ONE - 1);
    d.origin_x = $urandom_range(0, 3 * zq) - 3 * (zq / 2);
    d.origin_y = $urandom_range(0, 3 * zq) - 3 * (zq / 2);
    d.origin_z = zq;
    d.min_off_x = -$urandom_range(0, 8 * ONE);
    d.min_off_y = -$urandom_range(0, 8 * ONE);
    d.min_off_z = -$urandom_range(0, ONE);
    d.max_off_x = $urandom_range(0, 8 * ONE);
    d.max_off_y = $urandom_range(0, 8 * ONE);
    d.max_off_z = $urandom_range(0, 8 * ONE);
    if ($urandom_range(0, 7) == 0) d.min_off_x = $urandom_range(0, 4 * ONE);
    return d;
  endfunction

  function automatic logic [31:0] edge_word();
    case ($urandom_range(0, 4))
      0: return 32'h8000_0000;
      1: return 32'h7fff_ffff;
      2: return 32'h0000_0000;
      3: return 32'hffff_ffff;
      default: return $urandom;
    endcase
  endfunction

  function automatic pbb_in_t pick_box();
    pbb_in_t d;
    int sel;
    sel = $urandom_range(0, 9);
    if (sel < 8) return scene_box();
    d = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
         $urandom, $urandom};
    if (sel == 9) begin
      d.origin_x = edge_word(); d.origin_y = edge_word(); d.origin_z = edge_word();
      d.min_off_x = edge_word(); d.min_off_y = edge_word(); d.min_off_z = edge_word();
      d.max_off_x = edge_word(); d.max_off_y = edge_word(); d.max_off_z = edge_word();
    end
    return d;
  endfunction

  initial begin
    int sw, sh;
    pbb_in_t d;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset matrix is all zero, so every corner is behind the camera
    send_box(cube(0, 0, 10 * ONE, ONE));
    send_box(cube(ONE, -ONE, 50 * ONE, 3 * ONE));
    drain();

    // plain perspective, focal 1.0, full hd
    set_view(1'b0, ONE, 1920, 1080);
    send_box(cube(0, 0, 10 * ONE, ONE));
    send_box(cube(0, 0, 0, 0));
    send_box(cube(0, 0, 65, 0));          // z just below 0.001
    send_box(cube(0, 0, 66, 0));          // z just at 0.001
    send_box(cube(0, 0, 2 * ONE, 10 * ONE));
    send_box(cube(0, 0, 200 * ONE, 0));
    send_box(cube(100 * ONE, -100 * ONE, ONE, ONE / 2));
    send_box(cube(32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff));
    send_box(cube(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h7fff_ffff));
    d = cube(0, 0, 32'h7fff_0000, 0);
    d.max_off_z = 32'h7fff_ffff;           // corner overflow on z
    send_box(d);
    d = cube(-5 * ONE, 5 * ONE, 20 * ONE, 0);
    d.min_off_x = 4 * ONE;                 // minimum corner beyond the maximum
    d.max_off_x = -4 * ONE;
    send_box(d);
    send_box({9{32'hffff_ffff}});
    send_box({9{32'h8000_0000}});
    send_box({9{32'h7fff_ffff}});
    drain();

    // zero-sized and oversize screens
    set_view(1'b0, 2 * ONE, 0, 16383);
    send_box(cube(0, 0, 10 * ONE, ONE));
    send_box(cube(ONE, ONE, 3 * ONE, 2 * ONE));
    drain();
    set_view(1'b0, ONE / 2, 16383, 0);
    send_box(cube(-ONE, 2 * ONE, 8 * ONE, ONE));
    send_box(cube(0, 0, ONE / 4, ONE / 8));
    drain();

    for (int ph = 0; ph < 10; ph++) begin
      case (ph % 5)
        0: begin sw = $urandom_range(320, 4096); sh = $urandom_range(240, 4096); end
        1: begin sw = 1; sh = 1; end
        2: begin sw = 8192; sh = 8192; end
        3: begin sw = $urandom_range(1, 8192); sh = $urandom_range(1, 8192); end
        default: begin sw = $urandom_range(0, 16383); sh = $urandom_range(0, 16383); end
      endcase
      set_view(ph == 3, $urandom_range(ONE / 2, 3 * ONE), sw, sh);
      if (ph == 2) long_hold_req = 1'b1;
      if (ph == 9) begin
        tx_idle = 1'b0;
        rx_idle = 1'b0;
      end
      for (int n = 0; n < 113; n++) send_box(pick_box());
      drain();
    end

    if (fail_count == 0)
      $display("RESULT: OK");
    else
      $display("RESULT: ERROR");
    $finish;
  end

endmodule
